// ===== hw/rtl/mssb_pkg.sv =====
package mssb_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SID_IN_W = 3;
  localparam int unsigned STAT_W = 2;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP = 1'b1;

  localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_POP
  } state_t;

endpackage

// ===== hw/rtl/multi_stack_shared_buffer_core.sv =====
// Several stacks sharing one slot pool, linked by next pointers, with the
// unused slots threaded on a free list.
// Input channel: a command beat (in_mode, in_stack_id, in_value) is taken at a
// rising edge where start is high and busy is low. Push is in_mode 0, pop 1.
// Result channel: every command gives one result beat, shown for exactly one
// cycle with out_valid high; the receiver cannot stall it.
// Order: a push result is registered out of ST_HEAD, a successful pop
// result out of ST_POP after ST_HEAD, and a failed pop result out of ST_HEAD.
// No new command is taken until the last result is shown. A pop needs
// two dependent synchronous reads: the stack head memory, then the pool entry.
// A push reads the head and the free-list entry in the same cycle.
// busy drops in the cycle the result is shown, so the next command may be
// taken there.
// Reset: all stacks empty, free list holds every slot in order. No clearing
// pass: a fill mark stands in for the initial links of untouched slots.
module multi_stack_shared_buffer_core
  import mssb_pkg::*;
#(
  parameter int unsigned NUM_STACKS = 8,
  parameter int unsigned POOL_DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_mode,
  input  logic [SID_IN_W-1:0]      in_stack_id,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_popped_value
);

  localparam int unsigned PW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned AW = $clog2(POOL_DEPTH);
  localparam int unsigned SID_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int unsigned EW = PW + DATA_W;
  localparam logic [PW-1:0] NULL_PTR = PW'(POOL_DEPTH);

  logic [EW-1:0] pool_mem [POOL_DEPTH];
  logic [PW-1:0] head_mem [NUM_STACKS];

  state_t state_r, state_nxt;

  logic                     accept;
  logic                     mode_r;
  logic [SID_W-1:0]         sid_r;
  logic                     sid_ok_r;
  logic signed [DATA_W-1:0] value_r;
  logic [PW-1:0]            free_head_r, free_head_nxt;
  logic [PW-1:0]            fill_r, fill_nxt;
  logic [NUM_STACKS-1:0]    head_vld_r;
  logic [PW-1:0]            head_rd_r;
  logic                     head_rd_vld_r;
  logic [EW-1:0]            pool_rd_r;

  logic                     pool_re;
  logic [AW-1:0]            pool_raddr;
  logic                     pool_we;
  logic [AW-1:0]            pool_waddr;
  logic [EW-1:0]            pool_wdata;
  logic                     head_we;
  logic [PW-1:0]            head_wdata;

  logic                     res_vld_nxt;
  logic [STAT_W-1:0]        res_status_nxt;
  logic [DATA_W-1:0]        res_data_nxt;
  logic                     out_valid_r;
  logic [STAT_W-1:0]        out_status_r;
  logic [DATA_W-1:0]        out_data_r;

  logic [PW-1:0] head_ptr;
  logic          head_ok;
  logic          free_ok;
  logic [PW-1:0] rd_link;
  logic [PW-1:0] rd_link_norm;
  logic [PW-1:0] push_next;

  assign accept = start && (state_r == ST_IDLE);
  assign busy = (state_r != ST_IDLE);

  // head pointer seen this operation; corrupt values read as null
  assign head_ptr = (head_rd_vld_r && (head_rd_r < NULL_PTR)) ? head_rd_r : NULL_PTR;
  assign head_ok = (head_ptr < NULL_PTR);
  assign free_ok = (free_head_r < NULL_PTR);
  assign rd_link = pool_rd_r[EW-1:DATA_W];
  assign rd_link_norm = (rd_link < NULL_PTR) ? rd_link : NULL_PTR;
  // slots at or above the fill mark still hold their reset link
  assign push_next = (free_head_r == fill_r) ? PW'(free_head_r + 1'b1) : rd_link_norm;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (mode_r == MODE_POP && sid_ok_r && head_ok) begin
          state_nxt = ST_POP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pool_re = 1'b0;
    pool_raddr = free_head_r[AW-1:0];
    pool_we = 1'b0;
    pool_waddr = free_head_r[AW-1:0];
    pool_wdata = {head_ptr, value_r};
    head_we = 1'b0;
    head_wdata = free_head_r;
    free_head_nxt = free_head_r;
    fill_nxt = fill_r;
    res_vld_nxt = 1'b0;
    res_status_nxt = STAT_DONE;
    res_data_nxt = '0;
    unique case (state_r)
      ST_IDLE: begin
        pool_re = accept && (in_mode == MODE_PUSH) && free_ok;
      end
      ST_HEAD: begin
        if (mode_r == MODE_PUSH) begin
          res_vld_nxt = 1'b1;
          if (sid_ok_r && free_ok) begin
            pool_we = 1'b1;
            head_we = 1'b1;
            free_head_nxt = push_next;
            if (free_head_r == fill_r) begin
              fill_nxt = PW'(fill_r + 1'b1);
            end
          end else begin
            res_status_nxt = STAT_FULL;
          end
        end else begin
          if (sid_ok_r && head_ok) begin
            pool_re = 1'b1;
            pool_raddr = head_ptr[AW-1:0];
          end else begin
            res_vld_nxt = 1'b1;
            res_status_nxt = STAT_EMPTY;
          end
        end
      end
      ST_POP: begin
        pool_we = 1'b1;
        pool_waddr = head_ptr[AW-1:0];
        pool_wdata = {free_head_r, pool_rd_r[DATA_W-1:0]};
        head_we = 1'b1;
        head_wdata = rd_link_norm;
        free_head_nxt = head_ptr;
        res_vld_nxt = 1'b1;
        res_data_nxt = pool_rd_r[DATA_W-1:0];
      end
      default: begin
        res_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      free_head_r <= '0;
      fill_r <= '0;
      head_vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      free_head_r <= free_head_nxt;
      fill_r <= fill_nxt;
      if (head_we) begin
        head_vld_r[sid_r] <= 1'b1;
      end
      out_valid_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      sid_r <= SID_W'(in_stack_id);
      sid_ok_r <= (32'(in_stack_id) < NUM_STACKS);
      value_r <= in_value;
      head_rd_r <= head_mem[SID_W'(in_stack_id)];
      head_rd_vld_r <= head_vld_r[SID_W'(in_stack_id)];
    end
    if (head_we) begin
      head_mem[sid_r] <= head_wdata;
    end
    if (res_vld_nxt) begin
      out_status_r <= res_status_nxt;
      out_data_r <= res_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pool_re) begin
      pool_rd_r <= pool_mem[pool_raddr];
    end
    if (pool_we) begin
      pool_mem[pool_waddr] <= pool_wdata;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_popped_value = $signed(out_data_r);

endmodule

// ===== hw/rtl/mssb_checker.sv =====
module mssb_checker
  import mssb_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     in_mode,
  input logic                     out_valid,
  input logic [STAT_W-1:0]        out_status,
  input logic signed [DATA_W-1:0] out_popped_value
);

  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_mode == MODE_PUSH) |=> ##1 out_valid)
    else $error("push result beat missing");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beats in adjacent cycles");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while result beat shown");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_DONE) |-> (out_popped_value == '0))
    else $error("failed command returned nonzero word");

endmodule

bind multi_stack_shared_buffer_core mssb_checker u_mssb_checker (.*);

// ===== verif/multi_stack_shared_buffer_core_tb.sv =====
module multi_stack_shared_buffer_core_tb;
  import mssb_pkg::*;

  localparam int unsigned NSTK = 8;
  localparam int unsigned POOL = 256;
  localparam int unsigned LINK_W = 9;
  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(POOL);
  localparam int unsigned STALL_LIMIT = 400;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] popped;
  } stack_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_mode;
  logic [SID_IN_W-1:0]      in_stack_id;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_popped_value;

  logic [DATA_W-1:0] pool_data [POOL];
  logic [LINK_W-1:0] pool_link [POOL];
  logic [LINK_W-1:0] stack_top [NSTK];
  logic [LINK_W-1:0] free_top;
  int                stack_fill [NSTK];
  int                occupancy;

  stack_result_t expected_results [$];
  stack_result_t want;
  int            mismatches;
  int            stall_cycles;
  bit            idle_en;

  multi_stack_shared_buffer_core #(
    .NUM_STACKS(NSTK),
    .POOL_DEPTH(POOL)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_mode(in_mode),
    .in_stack_id(in_stack_id),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_popped_value(out_popped_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_stacks();
    for (int i = 0; i < POOL; i++) begin
      pool_data[i] = '0;
      pool_link[i] = LINK_W'(i + 1);
    end
    pool_link[POOL-1] = LINK_END;
    for (int s = 0; s < NSTK; s++) begin
      stack_top[s] = LINK_END;
      stack_fill[s] = 0;
    end
    free_top = '0;
    occupancy = 0;
  endfunction

  function automatic stack_result_t apply_stack_op(input logic op,
                                                   input logic [SID_IN_W-1:0] sid,
                                                   input logic [DATA_W-1:0] val);
    stack_result_t    r;
    logic [LINK_W-1:0] slot;
    logic [LINK_W-1:0] nxt;
    int unsigned       s;
    s = 32'(sid);
    r.status = STAT_DONE;
    r.popped = '0;
    if (op == MODE_PUSH) begin
      slot = free_top;
      if (s >= NSTK || slot >= POOL) begin
        r.status = STAT_FULL;
      end else begin
        nxt = pool_link[slot];
        free_top = (nxt < POOL) ? nxt : LINK_END;
        pool_data[slot] = val;
        pool_link[slot] = stack_top[s];
        stack_top[s] = slot;
        stack_fill[s]++;
        occupancy++;
      end
    end else begin
      if (s >= NSTK || stack_top[s] >= POOL) begin
        r.status = STAT_EMPTY;
      end else begin
        slot = stack_top[s];
        r.popped = pool_data[slot];
        nxt = pool_link[slot];
        stack_top[s] = (nxt < POOL) ? nxt : LINK_END;
        pool_link[slot] = free_top;
        free_top = slot;
        stack_fill[s]--;
        occupancy--;
      end
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] exp_v);
    if (mismatches < 100)
      $display("ERROR t=%0t %s: got %h exp %h", $time, what, got, exp_v);
    mismatches++;
  endtask

  // one command beat; optional idle burst ahead of it
  task automatic send_op(input logic op, input logic [SID_IN_W-1:0] sid,
                         input logic [DATA_W-1:0] val);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_mode <= op;
    in_stack_id <= sid;
    in_value <= val;
    do @(posedge clk); while (busy);
    expected_results.push_back(apply_stack_op(op, sid, val));
  endtask

  task automatic push_op(input int sid, input logic [DATA_W-1:0] val);
    send_op(MODE_PUSH, SID_IN_W'(sid), val);
  endtask

  task automatic pop_op(input int sid);
    send_op(MODE_POP, SID_IN_W'(sid), $urandom);
  endtask

  function automatic int busy_stack();
    int s;
    do s = $urandom_range(0, NSTK - 1); while (stack_fill[s] == 0);
    return s;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", {30'd0, out_status},
                        out_popped_value);
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", {30'd0, out_status}, {30'd0, want.status});
        if (out_popped_value !== want.popped)
          report_mismatch("popped_value", out_popped_value, want.popped);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_reset();
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    clear_stacks();
  endtask

  // empty pops, word extremes, LIFO order, slot reuse
  task automatic test_directed();
    idle_en = 1'b0;
    pop_op(0);
    pop_op(7);
    push_op(0, 32'h7fff_ffff);
    push_op(0, 32'h8000_0000);
    push_op(7, 32'h0000_0000);
    push_op(7, 32'hffff_ffff);
    push_op(3, 32'h5555_5555);
    push_op(4, 32'haaaa_aaaa);
    pop_op(0);
    pop_op(0);
    pop_op(0);
    pop_op(7);
    pop_op(7);
    pop_op(7);
    push_op(5, 32'h0000_0001);
    pop_op(5);
    push_op(5, 32'h1234_5678);
    pop_op(3);
    pop_op(4);
    pop_op(5);
    pop_op(1);
    pop_op(2);
    pop_op(6);
  endtask

  // fill the whole pool, hit full on every stack, then drain it
  task automatic test_pool_full();
    idle_en = 1'b1;
    while (occupancy < POOL) push_op($urandom_range(0, NSTK - 1), pick_value());
    for (int s = 0; s < NSTK; s++) push_op(s, pick_value());
    pop_op(busy_stack());
    push_op($urandom_range(0, NSTK - 1), pick_value());
    push_op($urandom_range(0, NSTK - 1), pick_value());
    idle_en = 1'b0;
    while (occupancy > 0) begin
      if ($urandom_range(0, 99) < 85) pop_op(busy_stack());
      else pop_op($urandom_range(0, NSTK - 1));
      if (occupancy == POOL / 2) idle_en = 1'b1;
    end
    pop_op($urandom_range(0, NSTK - 1));
  endtask

  task automatic test_random_mix();
    int push_pct;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0: push_pct = 20;
        1: push_pct = 50;
        2: push_pct = 80;
        default: push_pct = 95;
      endcase
      idle_en = (ph != 2);
      repeat (75) begin
        if ($urandom_range(0, 99) < push_pct)
          push_op($urandom_range(0, NSTK - 1), pick_value());
        else if (occupancy > 0 && $urandom_range(0, 3) != 0)
          pop_op(busy_stack());
        else
          pop_op($urandom_range(0, NSTK - 1));
      end
    end
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    repeat (150) begin
      if ($urandom_range(0, 1) == 0) push_op($urandom_range(0, NSTK - 1), pick_value());
      else pop_op($urandom_range(0, NSTK - 1));
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_PUSH;
    in_stack_id = '0;
    in_value = '0;
    mismatches = 0;
    idle_en = 1'b0;
    clear_stacks();
    test_reset();
    test_directed();
    test_pool_full();
    test_random_mix();
    test_back_to_back();
    drain_results();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mssb_pkg.sv
hw/rtl/multi_stack_shared_buffer_core.sv
hw/rtl/mssb_checker.sv
verif/multi_stack_shared_buffer_core_tb.sv
